FILE: sv/bfc_pkg.sv
// Shared types and constants for the box frustum cull test.
// No dependencies.
package bfc_pkg;
	localparam int CoordW = 32;
	localparam int NumSlots = 24;
	localparam int NumPlanes = 6;

	typedef enum logic [1:0] {
		KIND_PLANE = 2'd0,
		KIND_CORNER = 2'd1,
		KIND_TEST = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef logic signed [CoordW-1:0] coord_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_plane;
		logic load_corner;
		logic start;
		logic plane_en;
		logic [2:0] plane_idx;
	} bfc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic culled;
	} bfc_sts_t;
endpackage

FILE: sv/bfc_ctrl.sv
// Controller state machine for the box frustum cull test.
// Depends on bfc_pkg.
module bfc_ctrl import bfc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] kind,
	input logic [4:0] slot,
	output logic out_valid,
	input logic out_stall,
	output logic visible,
	output bfc_cmd_t cmd,
	input bfc_sts_t sts
);
	typedef enum logic [1:0] {S_IDLE, S_PLANE, S_LAST, S_DONE} state_t;
	state_t state_q;
	logic [2:0] plane_q;
	logic acc;

	assign in_stall = (state_q != S_IDLE) || out_valid;
	assign acc = in_valid && !in_stall;

	// The result beat carries the datapath's verdict, held while it waits.
	assign visible = !sts.culled;

	always_comb begin
		cmd = '0;
		cmd.load_plane = acc && kind == KIND_PLANE && slot < 5'(NumSlots);
		cmd.load_corner = acc && kind == KIND_CORNER && slot < 5'(NumSlots);
		cmd.start = acc && kind == KIND_TEST;
		cmd.plane_en = state_q == S_PLANE;
		cmd.plane_idx = plane_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			plane_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					plane_q <= '0;
					if (cmd.start) state_q <= S_PLANE;
				end
				S_PLANE: begin
					if (plane_q == 3'(NumPlanes - 1)) state_q <= S_LAST;
					else plane_q <= plane_q + 3'd1;
				end
				S_LAST: state_q <= S_DONE;
				S_DONE: begin
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: sv/bfc_dp.sv
// Datapath: coefficient and corner tables, eight corner dot products per
// cycle with a registered product stage, and the corner-versus-box test.
// Depends on bfc_pkg.
module bfc_dp import bfc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input bfc_cmd_t cmd,
	output bfc_sts_t sts,
	input logic [4:0] slot,
	input coord_t load_value,
	input coord_t box_min_x, box_min_y, box_min_z,
	input coord_t box_max_x, box_max_y, box_max_z
);
	coord_t plane_q [NumSlots];
	coord_t corner_q [NumSlots];
	coord_t bmin_q [3];
	coord_t bmax_q [3];
	logic signed [2*CoordW-1:0] px_s1 [8], py_s1 [8], pz_s1 [8];
	logic signed [2*CoordW-1:0] d_s1;
	logic valid_s1;
	logic cull_q;
	logic [7:0] neg;
	logic box_cull;

	always_ff @(posedge clk) begin
		if (cmd.load_plane) plane_q[slot] <= load_value;
		if (cmd.load_corner) corner_q[slot] <= load_value;
		if (cmd.start) begin
			bmin_q[0] <= box_min_x; bmin_q[1] <= box_min_y; bmin_q[2] <= box_min_z;
			bmax_q[0] <= box_max_x; bmax_q[1] <= box_max_y; bmax_q[2] <= box_max_z;
		end
		for (int k = 0; k < 8; k++) begin
			px_s1[k] <= plane_q[{cmd.plane_idx, 2'd0}] * (k[0] ? bmax_q[0] : bmin_q[0]);
			py_s1[k] <= plane_q[{cmd.plane_idx, 2'd1}] * (k[1] ? bmax_q[1] : bmin_q[1]);
			pz_s1[k] <= plane_q[{cmd.plane_idx, 2'd2}] * (k[2] ? bmax_q[2] : bmin_q[2]);
		end
		d_s1 <= {{(CoordW-16){plane_q[{cmd.plane_idx, 2'd3}][CoordW-1]}},
			plane_q[{cmd.plane_idx, 2'd3}], 16'd0};
	end

	always_comb begin
		logic signed [2*CoordW+1:0] s;
		for (int k = 0; k < 8; k++) begin
			s = (2*CoordW+2)'(px_s1[k]) + (2*CoordW+2)'(py_s1[k])
				+ (2*CoordW+2)'(pz_s1[k]) + (2*CoordW+2)'(d_s1);
			neg[k] = s[2*CoordW+1];
		end
	end

	always_comb begin
		box_cull = 1'b0;
		for (int a = 0; a < 3; a++) begin
			logic ab, be;
			ab = 1'b1; be = 1'b1;
			for (int k = 0; k < 8; k++) begin
				if (!(corner_q[k*3+a] > bmax_q[a])) ab = 1'b0;
				if (!(corner_q[k*3+a] < bmin_q[a])) be = 1'b0;
			end
			if (ab || be) box_cull = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cull_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.plane_en;
			if (cmd.start) cull_q <= 1'b0;
			else if ((valid_s1 && &neg) || (cmd.plane_en && box_cull)) cull_q <= 1'b1;
		end
	end

	assign sts.culled = cull_q;
endmodule

FILE: sv/box_frustum_cull_test.sv
// Top level of the box frustum cull test: joins controller and datapath.
// Depends on bfc_pkg, bfc_ctrl and bfc_dp.
//
// Load beats (kind 0 or 1) write one plane coefficient or one frustum corner
// coordinate and give no result; slots 24 to 31 and kind 3 are ignored. A
// test beat (kind 2) steps through the six planes, one plane a cycle with
// eight corner dot products in parallel behind a registered multiplier stage,
// then state S_LAST drains that stage and state S_DONE raises the result beat.
// The frustum-corner versus box comparison runs alongside the plane steps. All
// values are signed Q16.16; plane sums are exact, only their sign is used.
// Input is stalled while a test is in flight or a result awaits collection.
module box_frustum_cull_test import bfc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] kind,
	input logic [4:0] slot,
	input coord_t load_value,
	input coord_t box_min_x,
	input coord_t box_min_y,
	input coord_t box_min_z,
	input coord_t box_max_x,
	input coord_t box_max_y,
	input coord_t box_max_z,
	output logic out_valid,
	input logic out_stall,
	output logic visible
);
	bfc_cmd_t cmd;
	bfc_sts_t sts;

	bfc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .slot(slot), .out_valid(out_valid), .out_stall(out_stall),
		.visible(visible), .cmd(cmd), .sts(sts)
	);

	bfc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .slot(slot),
		.load_value(load_value),
		.box_min_x(box_min_x), .box_min_y(box_min_y), .box_min_z(box_min_z),
		.box_max_x(box_max_x), .box_max_y(box_max_y), .box_max_z(box_max_z)
	);
endmodule
